// ----- src/s1kev_pkg.sv -----
package s1kev_pkg;

	localparam logic [7:0] CODE_PREFIX  = 8'hE0;
	localparam logic [6:0] KEY_CTRL     = 7'h1D;
	localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT   = 7'h36;
	localparam logic [6:0] KEY_ALT      = 7'h38;
	localparam logic [6:0] KEY_CAPS     = 7'h3A;
	localparam logic [6:0] KEY_NUMLOCK  = 7'h45;
	localparam logic [6:0] KEY_SCROLL   = 7'h46;
	localparam logic [6:0] KEY_KP_MINUS = 7'h4A;
	localparam logic [6:0] KEY_KP_PLUS  = 7'h4E;
	localparam logic [6:0] KEY_LIMIT    = 7'h54;

	localparam logic [6:0] ASCII_MINUS   = 7'h2D;
	localparam logic [6:0] ASCII_PLUS    = 7'h2B;
	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
	localparam logic [6:0] CTRL_MASK     = 7'h1F;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 24;

	localparam logic [6:0] ROM_PLAIN [64] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] ROM_SHIFTED [64] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef struct packed {
		logic lshift;
		logic rshift;
		logic ctrl;
		logic alt;
		logic caps;
		logic ext;
	} kbd_state_t;

	typedef struct packed {
		logic       event_res;
		logic [6:0] character;
		logic [3:0] modifiers;
		logic [6:0] make_code;
	} key_event_t;

endpackage

// ----- src/s1kev_decode.sv -----
module s1kev_decode
	import s1kev_pkg::*;
(
	input  logic [7:0] code,
	input  kbd_state_t state_cur,
	output kbd_state_t state_nxt,
	output key_event_t event_out
);

	always_comb begin
		logic       brk;
		logic [6:0] key;
		logic [6:0] base;
		logic [6:0] shifted_ch;
		logic [6:0] ch;
		logic       shift;
		logic       swallow;
		logic       letter;
		logic       press;

		key        = code[6:0];
		brk        = code[7];
		state_nxt  = state_cur;
		swallow    = 1'b0;

		if (code == CODE_PREFIX) begin
			state_nxt.ext = 1'b1;
			swallow       = 1'b1;
		end else begin
			state_nxt.ext = 1'b0;
			unique case (key) inside
				KEY_LSHIFT: begin
					// Extended shift codes are fake shifts and leave the state alone.
					if (!state_cur.ext) begin
						state_nxt.lshift = !brk;
					end
					swallow = 1'b1;
				end
				KEY_RSHIFT: begin
					if (!state_cur.ext) begin
						state_nxt.rshift = !brk;
					end
					swallow = 1'b1;
				end
				KEY_CTRL: begin
					state_nxt.ctrl = !brk;
					swallow        = 1'b1;
				end
				KEY_ALT: begin
					state_nxt.alt = !brk;
					swallow       = 1'b1;
				end
				KEY_CAPS: begin
					if (!brk) begin
						state_nxt.caps = !state_cur.caps;
					end
					swallow = 1'b1;
				end
				KEY_NUMLOCK, KEY_SCROLL: begin
					swallow = 1'b1;
				end
				default: begin
					swallow = 1'b0;
				end
			endcase
		end

		shift      = state_cur.lshift | state_cur.rshift;
		base       = ROM_PLAIN[key[5:0]];
		shifted_ch = ROM_SHIFTED[key[5:0]];
		letter     = (base >= ASCII_LOWER_A) && (base <= ASCII_LOWER_Z);

		if (key[6]) begin
			// Keypad row: only minus and plus carry a character.
			if (key == KEY_KP_MINUS) begin
				ch = ASCII_MINUS;
			end else if (key == KEY_KP_PLUS) begin
				ch = ASCII_PLUS;
			end else begin
				ch = 7'h00;
			end
		end else if (letter) begin
			if (state_cur.ctrl) begin
				ch = base & CTRL_MASK;
			end else if (shift != state_cur.caps) begin
				ch = shifted_ch;
			end else begin
				ch = base;
			end
		end else begin
			ch = shift ? shifted_ch : base;
		end

		press = !swallow && !brk && (key < KEY_LIMIT);

		event_out.event_res = press;
		event_out.character = press ? ch : 7'h00;
		event_out.make_code = press ? key : 7'h00;
		event_out.modifiers = {state_nxt.alt, state_nxt.ctrl,
			state_nxt.lshift, state_nxt.rshift};
	end

endmodule

// ----- src/set1_scancode_to_key_event.sv -----
// An accepted word waits in the input register until the result register frees.
// Throughput: one word per cycle when m_tready does not stall the result register;
// while a result waits, one more word still enters.
// The rate is set by the single decode step between the input and result registers.
// Reset clears both valid flags and all modifier, caps lock and prefix state at once.
// Every input word gives exactly one result word.
module set1_scancode_to_key_event
	import s1kev_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,  // [7:0] code
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,  // [6:0] character, [10:7] modifiers,
	                                         // [17:11] make_code, [23:18] zero
	output logic                   m_tuser   // [0] event_res
);

	logic [7:0] code_s1;
	logic       valid_s1;
	key_event_t result_s2;
	logic       valid_s2;
	kbd_state_t state_q;
	kbd_state_t state_nxt;
	key_event_t event_nxt;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	s1kev_decode u_decode (
		.code      (code_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.event_out (event_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= s_tdata[7:0];
		end
		if (advance) begin
			result_s2 <= event_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.event_res;
	assign m_tdata  = {6'b0, result_s2.make_code, result_s2.modifiers, result_s2.character};

	a_prefix_sets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (code_s1 == CODE_PREFIX) |=> state_q.ext)
		else $error("prefix word did not set the pending flag");

	a_prefix_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (code_s1 != CODE_PREFIX) |=> !state_q.ext)
		else $error("pending prefix flag outlived the following word");

	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[6:0] == 7'h00) && (m_tdata[17:11] == 7'h00))
		else $error("result without key event carries a character or make code");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[17:11] < KEY_LIMIT))
		else $error("key event reported for a code off the table");

	a_mods_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tdata[10:7] == {state_q.alt, state_q.ctrl, state_q.lshift, state_q.rshift})
		else $error("reported modifier mask differs from tracked state");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import s1kev_pkg::*;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam logic [6:0] KEY_ESC      = 7'h01;
	localparam logic [6:0] KEY_1        = 7'h02;
	localparam logic [6:0] KEY_Q        = 7'h10;
	localparam logic [6:0] KEY_ENTER    = 7'h1C;
	localparam logic [6:0] KEY_A        = 7'h1E;
	localparam logic [6:0] KEY_S        = 7'h1F;
	localparam logic [6:0] KEY_Z        = 7'h2C;
	localparam logic [6:0] KEY_KP_DOT   = 7'h53;
	localparam logic [6:0] KEYPAD_FIRST = 7'h40;
	localparam logic [6:0] HELD_KEYS [5] = '{KEY_LSHIFT, KEY_RSHIFT, KEY_CTRL, KEY_ALT, KEY_CAPS};

	// ASCII per make code, without and with shift.
	localparam logic [6:0] PLAIN_CHARS [64] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};
	localparam logic [6:0] SHIFTED_CHARS [64] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tuser;

	// Keyboard state as the block should hold it.
	logic lshift_down = 1'b0;
	logic rshift_down = 1'b0;
	logic ctrl_down   = 1'b0;
	logic alt_down    = 1'b0;
	logic caps_on     = 1'b0;
	logic ext_pending = 1'b0;

	key_event_t pending_events [$];
	key_event_t oldest_event;
	int         error_count   = 0;
	int         cycle_count   = 0;
	int         send_idle_pct = 0;
	int         stall_pct     = 0;

	set1_scancode_to_key_event u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("set1_scancode_to_key_event regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] make_of(input logic [6:0] key);
		return {1'b0, key};
	endfunction

	function automatic logic [7:0] break_of(input logic [6:0] key);
		return {1'b1, key};
	endfunction

	// Applies one code to the tracked keyboard state and returns the event it gives.
	function automatic key_event_t decode_code(input logic [7:0] code);
		key_event_t ev;
		logic       prefixed;
		logic       is_break;
		logic [6:0] key;
		logic [6:0] base;
		logic       shift_held;

		ev = '0;
		if (code == CODE_PREFIX) begin
			ext_pending = 1'b1;
		end else begin
			prefixed = ext_pending;
			ext_pending = 1'b0;
			is_break = code[7];
			key = code[6:0];
			case (key)
				KEY_LSHIFT: if (!prefixed) lshift_down = !is_break;
				KEY_RSHIFT: if (!prefixed) rshift_down = !is_break;
				KEY_CTRL: ctrl_down = !is_break;
				KEY_ALT: alt_down = !is_break;
				KEY_CAPS: if (!is_break) caps_on = !caps_on;
				KEY_NUMLOCK, KEY_SCROLL: ;
				default: if (!is_break && key < KEY_LIMIT) begin
					ev.event_res = 1'b1;
					ev.make_code = key;
					shift_held = lshift_down || rshift_down;
					if (key >= KEYPAD_FIRST) begin
						if (key == KEY_KP_MINUS)
							ev.character = ASCII_MINUS;
						else if (key == KEY_KP_PLUS)
							ev.character = ASCII_PLUS;
					end else begin
						base = PLAIN_CHARS[key[5:0]];
						if (base >= ASCII_LOWER_A && base <= ASCII_LOWER_Z) begin
							// Caps lock flips the sense of shift; ctrl overrides both.
							ev.character = (shift_held != caps_on) ? SHIFTED_CHARS[key[5:0]] : base;
							if (ctrl_down)
								ev.character = base & CTRL_MASK;
						end else begin
							ev.character = shift_held ? SHIFTED_CHARS[key[5:0]] : base;
						end
					end
				end
			endcase
		end
		ev.modifiers = {alt_down, ctrl_down, lshift_down, rshift_down};
		return ev;
	endfunction

	task automatic flag_error(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Called right after a rising edge; returns right after the edge that takes the word.
	task automatic send_code(input logic [7:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		do
			@(posedge clk);
		while (!s_tready);
		pending_events.push_back(decode_code(code));
	endtask

	task automatic wait_events_drained();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				flag_error($sformatf("result word %h/%b with no event expected", m_tdata, m_tuser));
			end else begin
				oldest_event = pending_events.pop_front();
				if (m_tuser !== oldest_event.event_res)
					flag_error($sformatf("event_res got %b, expected %b",
						m_tuser, oldest_event.event_res));
				if (m_tdata[6:0] !== oldest_event.character)
					flag_error($sformatf("character got %h, expected %h",
						m_tdata[6:0], oldest_event.character));
				if (m_tdata[10:7] !== oldest_event.modifiers)
					flag_error($sformatf("modifiers got %h, expected %h",
						m_tdata[10:7], oldest_event.modifiers));
				if (m_tdata[17:11] !== oldest_event.make_code)
					flag_error($sformatf("make code got %h, expected %h",
						m_tdata[17:11], oldest_event.make_code));
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic test_field_extremes();
		send_code(8'h00);
		send_code(8'h7F);
		send_code(8'h80);
		send_code(8'hFF);
		send_code(make_of(KEY_KP_DOT));
	endtask

	task automatic test_locks_and_keypad();
		send_code(make_of(KEY_NUMLOCK));
		send_code(make_of(KEY_SCROLL));
		send_code(make_of(KEY_KP_MINUS));
		send_code(make_of(KEY_KP_PLUS));
	endtask

	task automatic test_shift_and_caps();
		send_code(make_of(KEY_LSHIFT));
		send_code(make_of(KEY_1));
		send_code(make_of(KEY_CAPS));
		send_code(make_of(KEY_A));
		send_code(break_of(KEY_LSHIFT));
		send_code(make_of(KEY_A));
		send_code(break_of(KEY_CAPS));
	endtask

	task automatic test_ctrl_and_alt();
		send_code(make_of(KEY_CTRL));
		send_code(make_of(KEY_S));
		send_code(break_of(KEY_CTRL));
		send_code(make_of(KEY_ALT));
		send_code(make_of(KEY_Z));
		send_code(break_of(KEY_ALT));
	endtask

	// A prefixed shift is a fake shift and must leave the shift state alone.
	task automatic test_prefix();
		send_code(CODE_PREFIX);
		send_code(make_of(KEY_RSHIFT));
		send_code(make_of(KEY_Q));
		send_code(CODE_PREFIX);
		send_code(make_of(KEY_ENTER));
		send_code(make_of(KEY_ESC));
	endtask

	function automatic logic [7:0] random_code();
		int pick;

		pick = $urandom_range(99);
		if (pick < 35)
			return make_of(7'($urandom_range(1, 83)));
		else if (pick < 55)
			return break_of(7'($urandom_range(1, 83)));
		else if (pick < 72)
			return {1'($urandom_range(1)), HELD_KEYS[$urandom_range(4)]};
		else if (pick < 84)
			return CODE_PREFIX;
		return 8'($urandom_range(255));
	endfunction

	task automatic test_random_stream(input int send_pct, input int stall, input int count);
		send_idle_pct = send_pct;
		stall_pct = stall;
		repeat (count)
			send_code(random_code());
		wait_events_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_locks_and_keypad();
		test_shift_and_caps();
		test_ctrl_and_alt();
		test_prefix();
		wait_events_drained();

		test_random_stream(0, 0, 280);
		test_random_stream(66, 0, 280);
		test_random_stream(0, 66, 280);
		test_random_stream(7, 7, 280);

		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_events.size() == 0)
			$display("set1_scancode_to_key_event regression: pass");
		else
			$display("set1_scancode_to_key_event regression: fail");
		$finish;
	end

endmodule
